@@ hdl/ole_pkg.sv @@
// Shared constants, types and cell commands for the ordered list engine.
`default_nettype none

package ole_pkg;

    localparam int DEPTH     = 16;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int VALUE_W   = 32;
    localparam int FUNC_W    = 2;
    localparam int POS_W     = 4;
    localparam int OCNT_W    = 5;
    localparam int RES_W     = 1 + 1 + POS_W + OCNT_W;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;
    localparam int S_TDATA_W = ((VALUE_W + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND  = 2'd0,
        FUNC_PREPEND = 2'd1,
        FUNC_ERASE   = 2'd2,
        FUNC_FIND    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_PREPEND,
        CELL_ERASE
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [VALUE_W-1:0]  key;
    } cell_cmd_t;

endpackage

`default_nettype wire

@@ hdl/ordered_list_engine.sv @@
// Top level of the ordered list engine: request sequencer, cell chain and result register.
`default_nettype none

// Ordered list of up to DEPTH signed 32-bit values held in a chain of cells, front at cell 0.
// One request is taken at a time. Push at back, push at front and find first register the
// request; then, once the output register is free, the cells compare or shift. Erase
// removes one match per cycle while the output register is free (the first match and the
// cells past it shift one place toward the front), until no match is left. A finished
// result waits in the output register while the next request is taken; the next result
// then waits until it is taken. Every request gives exactly one result.

module ordered_list_engine
    import ole_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // value[31:0]
    input  wire logic [FUNC_W-1:0]    s_tuser,   // func[1:0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata    // accepted, found, position[3:0], entry_count[4:0]
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t             state_reg;
    func_t              func_reg;
    logic [VALUE_W-1:0] key_reg;
    logic               found_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               m_valid_reg;
    logic [RES_W-1:0]   result_reg;

    cell_cmd_t          cmd;
    logic [VALUE_W-1:0] cell_value [DEPTH];
    logic [DEPTH-1:0]   cell_valid;
    logic [DEPTH-1:0]   match_vec;
    logic [DEPTH-1:0]   prefix_vec;
    logic [DEPTH-1:0]   first_vec;
    logic [IDX_W-1:0]   first_idx;
    logic               any_match;
    logic               full;
    logic               out_free;
    logic               done;
    logic               res_accepted;
    logic               res_found;
    logic [POS_W-1:0]   res_position;
    logic [CNT_W-1:0]   count_next;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [VALUE_W-1:0] lv;
            logic               lvd;
            logic [VALUE_W-1:0] rv;
            logic               rvd;
            if (g == 0) begin : g_first
                assign lv  = key_reg;
                assign lvd = 1'b1;
            end else begin : g_mid
                assign lv  = cell_value[g-1];
                assign lvd = cell_valid[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign rv  = key_reg;
                assign rvd = 1'b0;
            end else begin : g_inner
                assign rv  = cell_value[g+1];
                assign rvd = cell_valid[g+1];
            end
            ole_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .cmd         (cmd),
                .erase_here  (prefix_vec[g]),
                .left_value  (lv),
                .left_valid  (lvd),
                .right_value (rv),
                .right_valid (rvd),
                .value       (cell_value[g]),
                .valid       (cell_valid[g]),
                .match       (match_vec[g])
            );
        end
    endgenerate

    always_comb begin
        prefix_vec = '0;
        first_vec  = '0;
        first_idx  = '0;
        for (int i = 0; i < DEPTH; i++) begin
            for (int j = 0; j <= i; j++) begin
                prefix_vec[i] = prefix_vec[i] | match_vec[j];
            end
        end
        for (int i = 0; i < DEPTH; i++) begin
            first_vec[i] = (i == 0) ? match_vec[i] : (match_vec[i] & ~prefix_vec[i-1]);
        end
        for (int i = 0; i < DEPTH; i++) begin
            if (first_vec[i]) begin
                first_idx = first_idx | IDX_W'(i);
            end
        end
    end

    assign any_match = |match_vec;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign out_free  = !m_valid_reg || m_tready;

    always_comb begin
        cmd.op       = CELL_HOLD;
        cmd.key      = key_reg;
        done         = 1'b0;
        res_accepted = 1'b1;
        res_found    = 1'b0;
        res_position = '0;
        count_next   = count_reg;
        if (state_reg == ST_EXEC && out_free) begin
            unique case (func_reg)
                FUNC_APPEND: begin
                    done         = 1'b1;
                    res_accepted = !full;
                    if (!full) begin
                        cmd.op     = CELL_APPEND;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                FUNC_PREPEND: begin
                    done         = 1'b1;
                    res_accepted = !full;
                    if (!full) begin
                        cmd.op     = CELL_PREPEND;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                FUNC_ERASE: begin
                    if (any_match) begin
                        cmd.op     = CELL_ERASE;
                        count_next = count_reg - CNT_W'(1);
                    end else begin
                        done      = 1'b1;
                        res_found = found_reg;
                    end
                end
                FUNC_FIND: begin
                    done         = 1'b1;
                    res_found    = any_match;
                    res_position = POS_W'(first_idx);
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (done) begin
                m_valid_reg <= 1'b1;
                result_reg  <= {OCNT_W'(count_next), res_position, res_found,
                                res_accepted};
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        func_reg  <= func_t'(s_tuser);
                        key_reg   <= s_tdata[VALUE_W-1:0];
                        found_reg <= 1'b0;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (cmd.op == CELL_ERASE) begin
                        found_reg <= 1'b1;
                    end
                    if (done) begin
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - RES_W){1'b0}}, result_reg};

endmodule

`default_nettype wire

@@ hdl/ole_cell.sv @@
// One list slot: holds a value and its valid bit, compares against the key, shifts to neighbors.
`default_nettype none

module ole_cell
    import ole_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cell_cmd_t          cmd,
    input  wire logic               erase_here,
    input  wire logic [VALUE_W-1:0] left_value,
    input  wire logic               left_valid,
    input  wire logic [VALUE_W-1:0] right_value,
    input  wire logic               right_valid,
    output logic      [VALUE_W-1:0] value,
    output logic                    valid,
    output logic                    match
);

    logic [VALUE_W-1:0] value_reg;
    logic               valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            case (cmd.op)
                CELL_APPEND: begin
                    if (!valid_reg && left_valid) begin
                        valid_reg <= 1'b1;
                    end
                end
                CELL_PREPEND: begin
                    valid_reg <= left_valid;
                end
                CELL_ERASE: begin
                    if (erase_here) begin
                        valid_reg <= right_valid;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            CELL_APPEND: begin
                if (!valid_reg && left_valid) begin
                    value_reg <= cmd.key;
                end
            end
            CELL_PREPEND: begin
                value_reg <= left_value;
            end
            CELL_ERASE: begin
                if (erase_here) begin
                    value_reg <= right_value;
                end
            end
            default: begin
            end
        endcase
    end

    assign value = value_reg;
    assign valid = valid_reg;
    assign match = valid_reg && (value_reg == cmd.key);

endmodule

`default_nettype wire
